// ===== design/ctl_pkg.sv =====
`timescale 1ns / 1ps
package ctl_pkg;

  typedef enum logic [1:0] {
    ORG_SET_ASSOC = 2'd0,
    ORG_DIRECT    = 2'd1,
    ORG_FULL      = 2'd2,
    ORG_RSVD      = 2'd3
  } org_e;

  typedef enum logic [2:0] {
    REG_ORGANIZATION   = 3'd0,
    REG_SET_INDEX_BITS = 3'd1,
    REG_WAYS_IN_USE    = 3'd2,
    REG_OFFSET_BITS    = 3'd3,
    REG_LRU_POLICY     = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_AGE,
    ST_WRITE,
    ST_OUT
  } state_e;

  localparam int unsigned AddressBits = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned RankW    = 8;
  localparam logic [RankW-1:0] RankMax = '1;

endpackage

// ===== design/ctl_if.sv =====
`timescale 1ns / 1ps
interface ctl_req_if #(
  parameter int unsigned AddrW = ctl_pkg::AddressBits
);
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface ctl_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted;
  logic [31:0] evicted_tag;
  logic [31:0] hit_count;
  logic [31:0] access_count;

  modport source (output valid, output hit, output evicted, output evicted_tag,
                  output hit_count, output access_count, input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_tag,
                  input hit_count, input access_count, output ready);
endinterface

// ===== design/cache_tag_lookup_lru_fifo.sv =====
`timescale 1ns / 1ps
// Set size: W, the number of lines in
//   the addressed set (1 for direct mapped, up to 2^MAX_SET_BITS*MAX_WAYS fully associative).
// The set is walked one line per cycle by a single compare unit, then walked
//   again for the age update; a new request is taken only once the result is accepted.
// Reset: asynchronous, active low; clears valid bits and counters, returns configuration
//   to its defaults. Tags and age ranks stay undefined until their line is filled.
module cache_tag_lookup_lru_fifo #(
  parameter int unsigned MAX_SET_BITS = 5,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ctl_pkg::CfgDataW-1:0]  cfg_data_i,
  ctl_req_if.sink                       req,
  ctl_rsp_if.source                     rsp
);

  localparam int unsigned Lines  = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int unsigned LineW  = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int unsigned CntW   = $clog2(Lines + 1);
  localparam int unsigned WaysW  = $clog2(MAX_WAYS + 1);
  localparam int unsigned SbW    = $clog2(MAX_SET_BITS + 1) + 1;
  localparam int unsigned SetBW  = $clog2(MAX_SET_BITS + 5) + 1;
  localparam int unsigned RankW  = ctl_pkg::RankW;

  // configuration
  logic [1:0] org_q;
  logic [2:0] sib_q;
  logic [3:0] ways_q;
  logic [4:0] off_q;
  logic       lru_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q  <= ctl_pkg::ORG_SET_ASSOC;
      sib_q  <= '0;
      ways_q <= 4'd1;
      off_q  <= '0;
      lru_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ctl_pkg::REG_ORGANIZATION:   org_q  <= cfg_data_i[1:0];
        ctl_pkg::REG_SET_INDEX_BITS: sib_q  <= cfg_data_i[2:0];
        ctl_pkg::REG_WAYS_IN_USE:    ways_q <= cfg_data_i[3:0];
        ctl_pkg::REG_OFFSET_BITS:    off_q  <= cfg_data_i[4:0];
        ctl_pkg::REG_LRU_POLICY:     lru_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // geometry
  logic [SbW-1:0]   sb;
  logic [WaysW-1:0] ways;
  logic [1:0]       wlog;
  logic [SetBW-1:0] set_bits;
  logic [CntW-1:0]  set_ways;

  always_comb begin
    sb   = (SbW'(sib_q) > SbW'(MAX_SET_BITS)) ? SbW'(MAX_SET_BITS) : SbW'(sib_q);
    if (ways_q == 4'd0)                            ways = WaysW'(1);
    else if (32'(ways_q) > MAX_WAYS)               ways = WaysW'(MAX_WAYS);
    else                                           ways = WaysW'(ways_q);
    wlog = 2'd0;
    for (int b = 1; b < 4; b++) begin
      if ((32'(ways) >> b) != 0) wlog = 2'(b);
    end
    case (ctl_pkg::org_e'(org_q))
      ctl_pkg::ORG_DIRECT: begin
        set_bits = SetBW'(sb) + SetBW'(wlog);
        set_ways = CntW'(1);
      end
      ctl_pkg::ORG_FULL: begin
        set_bits = '0;
        set_ways = CntW'(CntW'(ways) << sb);
      end
      default: begin
        set_bits = SetBW'(sb);
        set_ways = CntW'(ways);
      end
    endcase
  end

  // line store
  logic [31:0]       tag_mem [Lines];
  logic [Lines-1:0]  valid_q;
  logic [RankW-1:0]  rank_mem [Lines];

  ctl_pkg::state_e   state_q, state_d;
  logic [LineW-1:0]  base_q;
  logic [CntW-1:0]   w_q;
  logic [31:0]       tag_q;
  logic              hit_q, havefree_q, cand_q;
  logic [CntW-1:0]   found_q, free_q, victim_q;
  logic [RankW-1:0]  vrank_q, below_q;
  logic [CntW-1:0]   slot_q;
  logic [31:0]       evtag_q;
  logic              evicted_q;
  logic [31:0]       hits_q, acc_q;
  logic [31:0]       rd_tag_q;
  logic [RankW-1:0]  rd_rank_q;

  logic [LineW-1:0]  idx;
  logic [LineW-1:0]  tag_rd_idx;
  logic [LineW-1:0]  slot_idx;
  logic [63:0]       addr_ext;
  logic [63:0]       above;
  logic [63:0]       set_mask;
  logic [LineW-1:0]  set_idx;

  assign addr_ext   = 64'(req.address);
  assign above      = addr_ext >> off_q;
  assign set_mask   = (64'd1 << set_bits) - 64'd1;
  assign set_idx    = LineW'(above & set_mask);
  assign idx        = LineW'(32'(base_q) + 32'(w_q));
  assign slot_idx   = LineW'(32'(base_q) + 32'(slot_q));
  // during the age walk, fetch the victim tag for the eviction report
  assign tag_rd_idx = (state_q == ctl_pkg::ST_AGE) ? LineW'(32'(base_q) + 32'(victim_q)) : idx;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ctl_pkg::ST_IDLE:   if (req.valid) state_d = ctl_pkg::ST_SCAN;
      ctl_pkg::ST_SCAN:   if (w_q == set_ways - CntW'(1)) state_d = ctl_pkg::ST_DECIDE;
      ctl_pkg::ST_DECIDE: state_d = ctl_pkg::ST_AGE;
      ctl_pkg::ST_AGE:    if (w_q == set_ways - CntW'(1)) state_d = ctl_pkg::ST_WRITE;
      ctl_pkg::ST_WRITE:  state_d = ctl_pkg::ST_OUT;
      ctl_pkg::ST_OUT:    if (rsp.ready) state_d = ctl_pkg::ST_IDLE;
      default:            state_d = ctl_pkg::ST_IDLE;
    endcase
  end

  assign req.ready = (state_q == ctl_pkg::ST_IDLE);
  assign rsp.valid = (state_q == ctl_pkg::ST_OUT);
  assign rsp.hit          = hit_q;
  assign rsp.evicted      = evicted_q;
  assign rsp.evicted_tag  = evtag_q;
  assign rsp.hit_count    = hits_q;
  assign rsp.access_count = acc_q;

  // tag memory: one read, one write port
  always_ff @(posedge clk_i) begin
    rd_tag_q <= tag_mem[tag_rd_idx];
    if (state_q == ctl_pkg::ST_WRITE && !hit_q)
      tag_mem[slot_idx] <= tag_q;
  end

  logic scan_valid_q;
  logic [CntW-1:0] scan_w_q;
  logic [LineW-1:0] scan_idx;

  assign scan_idx = LineW'(32'(base_q) + 32'(scan_w_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ctl_pkg::ST_IDLE;
      valid_q      <= '0;
      hits_q       <= '0;
      acc_q        <= '0;
      w_q          <= '0;
      scan_valid_q <= 1'b0;
      scan_w_q     <= '0;
      hit_q        <= 1'b0;
      havefree_q   <= 1'b0;
      cand_q       <= 1'b0;
      evicted_q    <= 1'b0;
      evtag_q      <= '0;
      found_q      <= '0;
      free_q       <= '0;
      victim_q     <= '0;
      vrank_q      <= '0;
      below_q      <= '0;
      slot_q       <= '0;
      base_q       <= '0;
      tag_q        <= '0;
    end else begin
      state_q      <= state_d;
      scan_valid_q <= (state_q == ctl_pkg::ST_SCAN);
      scan_w_q     <= w_q;
      // compare stage, working on the registered tag and rank reads
      if (scan_valid_q) begin
        if (valid_q[scan_idx]) begin
          if (!hit_q && rd_tag_q == tag_q) begin
            hit_q   <= 1'b1;
            found_q <= scan_w_q;
            below_q <= rd_rank_q;
          end
          if (!cand_q || rd_rank_q > vrank_q) begin
            victim_q <= scan_w_q;
            vrank_q  <= rd_rank_q;
          end
          cand_q <= 1'b1;
        end else if (!havefree_q) begin
          havefree_q <= 1'b1;
          free_q     <= scan_w_q;
        end
      end
      case (state_q)
        ctl_pkg::ST_IDLE: begin
          if (req.valid) begin
            base_q     <= LineW'(set_idx * set_ways);
            tag_q      <= 32'(above >> set_bits);
            w_q        <= '0;
            hit_q      <= 1'b0;
            havefree_q <= 1'b0;
            cand_q     <= 1'b0;
            vrank_q    <= '0;
            victim_q   <= '0;
            free_q     <= '0;
            found_q    <= '0;
          end
        end
        ctl_pkg::ST_SCAN: begin
          w_q <= (w_q == set_ways - CntW'(1)) ? '0 : w_q + CntW'(1);
        end
        ctl_pkg::ST_DECIDE: begin
          // last compare lands this cycle; settle slot next
          w_q <= '0;
        end
        ctl_pkg::ST_AGE: begin
          if (w_q == '0) begin
            if (hit_q) slot_q <= found_q;
            else       slot_q <= havefree_q ? free_q : victim_q;
          end
          w_q <= (w_q == set_ways - CntW'(1)) ? '0 : w_q + CntW'(1);
        end
        ctl_pkg::ST_WRITE: begin
          acc_q <= (acc_q == '1) ? acc_q : acc_q + 32'd1;
          if (hit_q) begin
            evicted_q <= 1'b0;
            evtag_q   <= '0;
            hits_q    <= (hits_q == '1) ? hits_q : hits_q + 32'd1;
          end else begin
            evicted_q        <= !havefree_q;
            evtag_q          <= havefree_q ? 32'd0 : rd_tag_q;
            valid_q[slot_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // age pass: second walk over the set with the chosen slot known
  logic [CntW-1:0]  age_w_q;
  logic             age_on_q;
  logic             age_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_w_q   <= '0;
      age_on_q  <= 1'b0;
      age_hit_q <= 1'b0;
    end else begin
      age_on_q  <= (state_q == ctl_pkg::ST_AGE);
      age_w_q   <= w_q;
      age_hit_q <= hit_q;
    end
  end

  logic [LineW-1:0] age_idx;
  logic             age_en;
  assign age_idx = LineW'(32'(base_q) + 32'(age_w_q));
  assign age_en  = age_on_q && (!age_hit_q || lru_q) && (age_w_q != slot_q)
                   && valid_q[age_idx] && (!age_hit_q || rd_rank_q < below_q)
                   && rd_rank_q != ctl_pkg::RankMax;

  // rank memory: one read, one write port; the write lands in the cycle after the read
  always_ff @(posedge clk_i) begin
    rd_rank_q <= rank_mem[idx];
    if (age_on_q && age_w_q == slot_q) begin
      if (!age_hit_q || lru_q) rank_mem[age_idx] <= '0;
    end else if (age_en) begin
      rank_mem[age_idx] <= rd_rank_q + RankW'(1);
    end
  end

endmodule

// ===== design/ctl_checker.sv =====
`timescale 1ns / 1ps
module ctl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        hit,
  input logic        evicted,
  input logic [31:0] evicted_tag,
  input logic [31:0] hit_count,
  input logic [31:0] access_count
);

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !(hit && evicted)) else $error("hit with eviction");

  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !evicted) |-> evicted_tag == 32'd0) else $error("stray evicted tag");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("ready while result pending");

  // hold the result while the sink stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(hit) && $stable(evicted)
      && $stable(evicted_tag) && $stable(hit_count) && $stable(access_count))
    else $error("result changed while stalled");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !req_ready) else $error("ready right after request");

endmodule

bind cache_tag_lookup_lru_fifo ctl_checker u_ctl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .hit          (rsp.hit),
  .evicted      (rsp.evicted),
  .evicted_tag  (rsp.evicted_tag),
  .hit_count    (rsp.hit_count),
  .access_count (rsp.access_count)
);
